// ===== rtl/soc_pkg.sv =====
// Shared types, constants and helper functions for the subsequence occurrence counter.
// Depends on nothing; every other file in rtl/ imports this package.
package soc_pkg;

  // Sizes of the stores and fields.
  localparam int PATTERN_MAX = 64;
  localparam int IDX_W       = $clog2(PATTERN_MAX);
  localparam int LEN_W       = 7;
  localparam int SYM_W       = 8;
  localparam int COUNT_W     = 30;
  localparam int FUNC_W      = 2;

  // Counts are kept modulo this prime.
  localparam logic [COUNT_W:0] COUNT_MOD = (COUNT_W + 1)'(1000000007);

  // Command codes on the func input.
  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TEXT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_END  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_pat;    // write the pattern symbol of the accepted beat
    logic scan_start;  // latch the text symbol and rewind the prefix sweep
    logic scan_step;   // read one prefix entry and advance the sweep
    logic emit_read;   // read the count of the full pattern
    logic emit_out;    // present the result and clear all counts
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;   // the sweep is reading the last prefix entry
  } status_t;

  // Sum of two residues, reduced by one conditional subtraction.
  function automatic logic [COUNT_W-1:0] add_mod(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= COUNT_MOD) begin
      s = s - COUNT_MOD;
    end
    return s[COUNT_W-1:0];
  endfunction

endpackage

// ===== rtl/soc_datapath.sv =====
// Datapath: pattern memory, prefix count memory with valid bits, and the
// read-modify-write sweep that updates one prefix per cycle. Uses soc_pkg.
module soc_datapath
  import soc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic [IDX_W-1:0]    pattern_index,
  input  logic [SYM_W-1:0]    symbol,
  input  logic                length_we,
  input  logic [LEN_W-1:0]    pattern_length,
  output logic [COUNT_W-1:0]  occurrence_count
);

  logic [SYM_W-1:0]   pattern_mem [PATTERN_MAX];
  logic [COUNT_W-1:0] count_mem   [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] count_valid;

  logic [LEN_W-1:0]   length_reg;
  logic [SYM_W-1:0]   text_sym;
  logic [IDX_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   wb_addr;
  logic               wb_valid;
  logic [COUNT_W-1:0] prev_old;
  logic               zero_len;

  logic [SYM_W-1:0]   pat_rd_data;
  logic [COUNT_W-1:0] cnt_rd_data;
  logic               cnt_rd_valid;

  logic [IDX_W-1:0]   cnt_rd_addr;
  logic [IDX_W-1:0]   emit_addr;
  logic [COUNT_W-1:0] old_count;
  logic [COUNT_W-1:0] new_count;

  // Pattern length register, written from the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      length_reg <= '0;
    end else if (length_we) begin
      length_reg <= pattern_length;
    end
  end

  // Address of the full-pattern count; lengths above the store saturate.
  always_comb begin
    if (length_reg >= LEN_W'(PATTERN_MAX)) begin
      emit_addr = IDX_W'(PATTERN_MAX - 1);
    end else begin
      emit_addr = length_reg[IDX_W-1:0] - IDX_W'(1);
    end
  end

  assign cnt_rd_addr = cmd.emit_read ? emit_addr : scan_idx;

  // Pattern memory: written on a load beat, read along the sweep.
  always_ff @(posedge clk) begin
    if (cmd.load_pat) begin
      pattern_mem[pattern_index] <= symbol;
    end
    pat_rd_data <= pattern_mem[scan_idx];
  end

  // Count memory: registered read, write back from the update stage.
  always_ff @(posedge clk) begin
    if (wb_valid) begin
      count_mem[wb_addr] <= new_count;
    end
    cnt_rd_data  <= count_mem[cnt_rd_addr];
    cnt_rd_valid <= count_valid[cnt_rd_addr];
  end

  // Valid bits stand in for the all-zero reset and the end-of-text clear.
  always_ff @(posedge clk) begin
    if (rst || cmd.emit_out) begin
      count_valid <= '0;
    end else if (wb_valid) begin
      count_valid[wb_addr] <= 1'b1;
    end
  end

  // Sweep counter and the update stage that follows the read.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= cmd.scan_step;
      if (cmd.scan_start) begin
        scan_idx <= '0;
      end else if (cmd.scan_step) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
    end
  end

  // Sweep payload: text symbol, write address and the previous-row count below.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      text_sym <= symbol;
      prev_old <= COUNT_W'(1);
    end else if (wb_valid) begin
      prev_old <= old_count;
    end
    if (cmd.scan_step) begin
      wb_addr <= scan_idx;
    end
    if (cmd.emit_read) begin
      zero_len <= (length_reg == '0);
    end
  end

  // A matching prefix gains the old count of the prefix one shorter.
  assign old_count = cnt_rd_valid ? cnt_rd_data : '0;
  assign new_count = (pat_rd_data == text_sym) ? add_mod(old_count, prev_old) : old_count;

  assign status.scan_last = (scan_idx == IDX_W'(PATTERN_MAX - 1));

  // An empty pattern occurs exactly once.
  assign occurrence_count = zero_len ? COUNT_W'(1) : (cnt_rd_valid ? cnt_rd_data : '0);

  // Every count written back is a reduced residue.
  a_wb_reduced : assert property (@(posedge clk) disable iff (rst)
    wb_valid |-> ({1'b0, new_count} < COUNT_MOD))
    else $error("count written back is not reduced");

  // The count carried from the row below stays reduced during a sweep.
  a_prev_reduced : assert property (@(posedge clk) disable iff (rst)
    wb_valid |-> ({1'b0, prev_old} < COUNT_MOD))
    else $error("carried count is not reduced");

  // Write-back addresses follow the sweep index through a register.
  a_wb_follows : assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step && !cmd.scan_start |=> wb_valid && (wb_addr == $past(scan_idx)))
    else $error("write-back address does not follow the sweep");

endmodule

// ===== rtl/soc_controller.sv =====
// Controller state machine: decodes accepted beats and sequences the prefix
// sweep and the result cycle. Uses soc_pkg for codes and command types.
module soc_controller
  import soc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [FUNC_W-1:0] func,
  input  status_t           status,
  output cmd_t              cmd,
  output logic              busy,
  output logic              done
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign accept = start && (state == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (func)
            FUNC_LOAD: begin
              cmd.load_pat = 1'b1;
            end
            FUNC_TEXT: begin
              cmd.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
            FUNC_END: begin
              cmd.emit_read = 1'b1;
              state_next    = ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_IDLE;
      end
      ST_EMIT: begin
        cmd.emit_out = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_EMIT);

  // A text beat starts the sweep on the next cycle.
  a_text_scans : assert property (@(posedge clk) disable iff (rst)
    accept && (func == FUNC_TEXT) |=> (state == ST_SCAN))
    else $error("text beat did not start the sweep");

  // The result strobe lasts one cycle and frees the block.
  a_done_once : assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe held too long");

  // The drain cycle only follows the last sweep read.
  a_drain_after_scan : assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && status.scan_last |=> (state == ST_DRAIN))
    else $error("sweep did not drain after its last read");

endmodule

// ===== rtl/subsequence_occurrence_counter.sv =====
// Top level of the subsequence occurrence counter: ties the controller to
// the datapath. Depends on soc_pkg, soc_controller and soc_datapath.
//
// Counts occurrences of the loaded pattern as a subsequence of the text,
// modulo 1000000007. A beat is taken when start is high and busy is low.
// A pattern load (func 0) leaves busy low, so loads can follow back to back.
// A text symbol (func 1) keeps busy high while the prefix count memory is
// swept with one read-modify-write per prefix over all 64 prefixes, and
// through a drain state for the last write back. An end-of-text beat
// (func 2) raises done with occurrence_count for exactly the next cycle and
// clears all counts; busy is high in that cycle. The receiver cannot stall,
// so the result must be taken in that cycle. Write pattern_length with
// length_we only while busy is low.
module subsequence_occurrence_counter
  import soc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [FUNC_W-1:0]  func,
  input  logic [IDX_W-1:0]   pattern_index,
  input  logic [SYM_W-1:0]   symbol,
  output logic               done,
  output logic [COUNT_W-1:0] occurrence_count,
  input  logic               length_we,
  input  logic [LEN_W-1:0]   pattern_length
);

  cmd_t    cmd;
  status_t status;

  // Sequencing of beats.
  soc_controller u_controller (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Stores and arithmetic.
  soc_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .pattern_index    (pattern_index),
    .symbol           (symbol),
    .length_we        (length_we),
    .pattern_length   (pattern_length),
    .occurrence_count (occurrence_count)
  );

endmodule
